// ===== rtl/swmd_pkg.sv =====
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared types and codes for the stack with match delete block.
// ----------------------------------------------------------------------------
package swmd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_PEEK   = 2'd2;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture func and value of the accepted word
        logic push;         // write value on top, report ok
        logic full_err;     // report full
        logic empty_err;    // report empty
        logic top_read;     // read the top entry
        logic top_deliver;  // report the word read, drop it on pop
        logic walk_init;    // reset compaction pointers
        logic walk_step;    // at most one read and one conditional write of the walk
        logic walk_deliver; // commit new count, report ok
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic              empty;
        logic              full;
        logic              walk_done;
    } t_stat;

endpackage

// ===== rtl/swmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmd_ctrl
// Sequencer: decodes the captured operation and steps the datapath.
// ----------------------------------------------------------------------------
module swmd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  swmd_pkg::t_stat  i_stat,
    output swmd_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_TOP  = 2'd2;
    localparam logic [1:0] S_WALK = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.op)
                    swmd_pkg::OP_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.full_err = 1'b1;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    swmd_pkg::OP_POP, swmd_pkg::OP_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.empty_err = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            o_cmd.top_read = 1'b1;
                            n_state        = S_TOP;
                        end
                    end
                    default: begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_WALK;
                    end
                endcase
            end
            S_TOP: begin
                o_cmd.top_deliver = 1'b1;
                n_state           = S_IDLE;
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    o_cmd.walk_deliver = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/swmd_dpath.sv =====
// ----------------------------------------------------------------------------
// swmd_dpath
// Word memory, fill count, compaction pointers and result registers.
// ----------------------------------------------------------------------------
module swmd_dpath #(
    parameter int DEPTH = swmd_pkg::DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [swmd_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [swmd_pkg::DATA_W-1:0]     i_value,
    input  swmd_pkg::t_cmd                         i_cmd,
    output swmd_pkg::t_stat                        o_stat,
    output logic                                   o_done,
    output logic [swmd_pkg::STAT_W-1:0]            o_status,
    output logic signed [swmd_pkg::DATA_W-1:0]     o_top_word,
    output logic [swmd_pkg::CNT_OUT_W-1:0]         o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > swmd_pkg::CNT_OUT_W) ? CW : swmd_pkg::CNT_OUT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [swmd_pkg::DATA_W-1:0]        mem [DEPTH];
    logic [swmd_pkg::DATA_W-1:0]        r_rdata;
    logic [swmd_pkg::FUNC_W-1:0]        r_op;
    logic signed [swmd_pkg::DATA_W-1:0] r_value;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_rd;
    logic [CW-1:0]                      r_wr;
    logic                               r_pend;
    logic                               r_done;
    logic [swmd_pkg::STAT_W-1:0]        r_status;
    logic signed [swmd_pkg::DATA_W-1:0] r_word;

    logic                               w_issue;
    logic                               w_keep;
    logic                               w_we;
    logic                               w_re;
    logic [AW-1:0]                      w_waddr;
    logic [AW-1:0]                      w_raddr;
    logic [swmd_pkg::DATA_W-1:0]        w_wdata;
    logic [CW-1:0]                      w_top_idx;
    logic [XW-1:0]                      w_cnt_ext;

    assign w_top_idx = r_count - CW'(1);
    // walk reads ahead of the write pointer, so ports never collide
    assign w_issue   = i_cmd.walk_step && (r_rd != r_count);
    assign w_keep    = i_cmd.walk_step && r_pend && (r_rdata != r_value);

    assign w_we    = i_cmd.push || w_keep;
    assign w_waddr = i_cmd.push ? r_count[AW-1:0] : r_wr[AW-1:0];
    assign w_wdata = i_cmd.push ? r_value : r_rdata;
    assign w_re    = i_cmd.top_read || w_issue;
    assign w_raddr = i_cmd.top_read ? w_top_idx[AW-1:0] : r_rd[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_func;
            r_value <= i_value;
        end
        if (i_cmd.walk_init) begin
            r_rd <= '0;
            r_wr <= '0;
        end else if (i_cmd.walk_step) begin
            if (w_issue) begin
                r_rd <= r_rd + CW'(1);
            end
            if (w_keep) begin
                r_wr <= r_wr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
            r_status <= swmd_pkg::ST_OK;
            r_word   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.walk_init) begin
                r_pend <= 1'b0;
            end else if (i_cmd.walk_step) begin
                r_pend <= w_issue;
            end
            if (i_cmd.push) begin
                r_count  <= r_count + CW'(1);
                r_done   <= 1'b1;
                r_status <= swmd_pkg::ST_OK;
                r_word   <= '0;
            end
            if (i_cmd.full_err) begin
                r_done   <= 1'b1;
                r_status <= swmd_pkg::ST_FULL;
                r_word   <= '0;
            end
            if (i_cmd.empty_err) begin
                r_done   <= 1'b1;
                r_status <= swmd_pkg::ST_EMPTY;
                r_word   <= '0;
            end
            if (i_cmd.top_deliver) begin
                if (r_op == swmd_pkg::OP_POP) begin
                    r_count <= w_top_idx;
                end
                r_done   <= 1'b1;
                r_status <= swmd_pkg::ST_OK;
                r_word   <= r_rdata;
            end
            if (i_cmd.walk_deliver) begin
                r_count  <= r_wr;
                r_done   <= 1'b1;
                r_status <= swmd_pkg::ST_OK;
                r_word   <= '0;
            end
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == FULL_CNT);
    assign o_stat.walk_done = !r_pend && (r_rd == r_count);

    assign w_cnt_ext     = XW'(r_count);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_top_word    = r_word;
    assign o_entry_count = w_cnt_ext[swmd_pkg::CNT_OUT_W-1:0];

endmodule

// ===== rtl/stack_with_match_delete.sv =====
// ----------------------------------------------------------------------------
// stack_with_match_delete
// Bounded LIFO of 32-bit words with push, pop, peek and delete-all-matching.
// ----------------------------------------------------------------------------
// A word is taken when i_start is high and o_busy is low. Its single result
// appears on o_status, o_top_word and o_entry_count for one cycle with o_done
// high, and must be captured then: there is no way to hold it off. Push
// writes and reports directly; pop and peek first do one registered memory
// read of the top entry. Delete walks the stored entries through one read
// port and one write port of the word memory and compacts them in place. A
// push onto a full stack is dropped and flagged; pop or peek on an empty
// stack is flagged. o_entry_count reports the fill count masked to its 7 bits.
module stack_with_match_delete #(
    parameter int DEPTH = swmd_pkg::DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic [swmd_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [swmd_pkg::DATA_W-1:0]     i_value,
    output logic                                   o_done,
    output logic [swmd_pkg::STAT_W-1:0]            o_status,
    output logic signed [swmd_pkg::DATA_W-1:0]     o_top_word,
    output logic [swmd_pkg::CNT_OUT_W-1:0]         o_entry_count
);

    swmd_pkg::t_cmd  w_cmd;
    swmd_pkg::t_stat w_stat;

    swmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    swmd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_top_word    (o_top_word),
        .o_entry_count (o_entry_count)
    );

endmodule
